// ===== hdl/csss_pkg.sv =====
// Package: shared types and constants for the current step stimulus sequencer.
`default_nettype none

package csss_pkg;

  // Fixed field widths
  localparam int LEVEL_W = 16;
  localparam int SPAN_W  = LEVEL_W + 1;
  localparam int OFFS_W  = LEVEL_W + 2;
  localparam int SUM_W   = LEVEL_W + 3;
  localparam int INC_W   = 15;
  localparam int CYC_W   = 16;
  localparam int CFG_W   = 32;
  localparam int CIDX_W  = 3;

  // Register indexes on the configuration port
  localparam logic [CIDX_W-1:0] CFG_PULSE_TICKS    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_DOWNTIME_TICKS = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_ICI_TICKS      = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_START_LEVEL    = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_END_LEVEL      = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_INCREMENT      = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_N_CYCLES       = 3'd6;

  // Reset values of the level, increment and cycle-count registers
  localparam logic signed [LEVEL_W-1:0] START_RST = -16'sd100;
  localparam logic signed [LEVEL_W-1:0] END_RST   = 16'sd380;
  localparam logic [INC_W-1:0]          INC_RST   = 15'd20;
  localparam logic [CYC_W-1:0]          NCYC_RST  = 16'd1;

  // Sequencer phase
  typedef enum logic [1:0] {
    PH_PULSE = 2'd0,
    PH_DOWN  = 2'd1,
    PH_GAP   = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

endpackage

`default_nettype wire

// ===== hdl/current_step_stimulus_sequencer_core.sv =====
// Top level: current step stimulus sequencer with input, step and result registers.
// Path: an accepted item is registered in the input stage, then in the result stage (out_valid high after).
// Throughput: one item per cycle while out_ready does not stall the result stage; the state update for a tick
// is one add and compare on the level offset and one increment and compare on the tick counter.
// Reset (rst, synchronous): registers return to their default values, the sequencer
// starts in the pulse phase with all counters at zero, and both pipeline stages empty.
`default_nettype none

module current_step_stimulus_sequencer_core import csss_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // tick items
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      restart,
  // result items
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [LEVEL_W-1:0]      current,
  output logic                           stimulating,
  output logic                           done_res,
  // configuration writes
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CIDX_W-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_data
);

  localparam logic [TIME_BITS-1:0] PULSE_RST = TIME_BITS'(32'd2500);
  localparam logic [TIME_BITS-1:0] DOWN_RST  = TIME_BITS'(32'd5560);
  localparam logic [TIME_BITS-1:0] ICI_RST   = TIME_BITS'(32'd50000);
  localparam logic [TIME_BITS-1:0] T_ONE     = TIME_BITS'(1);

  // configuration registers
  logic [TIME_BITS-1:0]        pulse_ticks;
  logic [TIME_BITS-1:0]        downtime_ticks;
  logic [TIME_BITS-1:0]        ici_ticks;
  logic signed [LEVEL_W-1:0]   start_level;
  logic signed [LEVEL_W-1:0]   end_level;
  logic [INC_W-1:0]            increment;
  logic [CYC_W-1:0]            n_cycles;

  // sequencer state
  phase_t                      phase, phase_next;
  logic [TIME_BITS-1:0]        tick_count, tick_count_next;
  logic signed [OFFS_W-1:0]    level_offset, level_offset_next;
  logic [CYC_W-1:0]            cycle_count, cycle_count_next;

  // pipeline registers and next result values
  logic                        s1_valid;
  logic                        s1_restart;
  logic signed [LEVEL_W-1:0]   cur_next;
  logic                        stim_next, done_next;

  logic cfg_fire, in_fire, advance;

  // step-stage working values
  phase_t                      ph;
  logic [TIME_BITS-1:0]        tc, tc_inc, pt;
  logic signed [OFFS_W-1:0]    off;
  logic [CYC_W-1:0]            cc, cc_inc, cyc_eff;
  logic signed [SPAN_W-1:0]    diff;
  logic [SPAN_W-1:0]           span;
  logic signed [SUM_W-1:0]     inc_s, off_sum, mag;
  logic                        wrap;
  phase_t                      step_phase;
  logic signed [OFFS_W-1:0]    step_off;
  logic [CYC_W-1:0]            step_cc;

  // handshakes
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign advance   = s1_valid & (~out_valid | out_ready);
  assign in_ready  = ~s1_valid | advance;
  assign in_fire   = in_valid & in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_ticks    <= PULSE_RST;
      downtime_ticks <= DOWN_RST;
      ici_ticks      <= ICI_RST;
      start_level    <= START_RST;
      end_level      <= END_RST;
      increment      <= INC_RST;
      n_cycles       <= NCYC_RST;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_PULSE_TICKS:    pulse_ticks    <= TIME_BITS'(cfg_data);
        CFG_DOWNTIME_TICKS: downtime_ticks <= TIME_BITS'(cfg_data);
        CFG_ICI_TICKS:      ici_ticks      <= TIME_BITS'(cfg_data);
        CFG_START_LEVEL:    start_level    <= cfg_data[LEVEL_W-1:0];
        CFG_END_LEVEL:      end_level      <= cfg_data[LEVEL_W-1:0];
        CFG_INCREMENT:      increment      <= cfg_data[INC_W-1:0];
        CFG_N_CYCLES:       n_cycles       <= cfg_data[CYC_W-1:0];
        default: ;
      endcase
    end
  end

  // constant-per-run derived values
  always_comb begin
    pt      = (pulse_ticks == '0) ? T_ONE : pulse_ticks;
    cyc_eff = (n_cycles == '0) ? CYC_W'(1) : n_cycles;
    diff    = SPAN_W'(end_level) - SPAN_W'(start_level);
    span    = (diff < 0) ? SPAN_W'(-diff) : SPAN_W'(diff);
    inc_s   = (start_level > end_level) ? -SUM_W'(increment) : SUM_W'(increment);
  end

  // state seen by this tick, after an optional restart
  always_comb begin
    ph  = s1_restart ? PH_PULSE : phase;
    tc  = s1_restart ? '0 : tick_count;
    off = s1_restart ? '0 : level_offset;
    cc  = s1_restart ? '0 : cycle_count;
  end

  // end-of-step offset move and cycle wrap
  always_comb begin
    off_sum    = SUM_W'(off) + inc_s;
    mag        = (off_sum < 0) ? -off_sum : off_sum;
    wrap       = mag > $signed({2'b00, span});
    cc_inc     = cc + CYC_W'(1);
    step_off   = wrap ? '0 : OFFS_W'(off_sum);
    step_cc    = wrap ? cc_inc : cc;
    if (!wrap) begin
      step_phase = PH_PULSE;
    end else if (cc_inc >= cyc_eff) begin
      step_phase = PH_DONE;
    end else if (ici_ticks == '0) begin
      step_phase = PH_PULSE;
    end else begin
      step_phase = PH_GAP;
    end
  end

  // tick processing
  always_comb begin
    tc_inc            = tc + T_ONE;
    phase_next        = ph;
    tick_count_next   = tc;
    level_offset_next = off;
    cycle_count_next  = cc;
    cur_next          = '0;
    stim_next         = 1'b0;
    done_next         = 1'b0;
    if (ph == PH_DONE || cc >= cyc_eff) begin
      phase_next = PH_DONE;
      done_next  = 1'b1;
    end else begin
      case (ph)
        PH_PULSE: begin
          cur_next        = LEVEL_W'(SUM_W'(start_level) + SUM_W'(off));
          stim_next       = 1'b1;
          tick_count_next = tc_inc;
          if (tc_inc >= pt) begin
            tick_count_next = '0;
            if (downtime_ticks == '0) begin
              phase_next        = step_phase;
              level_offset_next = step_off;
              cycle_count_next  = step_cc;
            end else begin
              phase_next = PH_DOWN;
            end
          end
        end
        PH_DOWN: begin
          tick_count_next = tc_inc;
          if (tc_inc >= downtime_ticks) begin
            tick_count_next   = '0;
            phase_next        = step_phase;
            level_offset_next = step_off;
            cycle_count_next  = step_cc;
          end
        end
        default: begin
          tick_count_next = tc_inc;
          if (tc_inc >= ici_ticks) begin
            tick_count_next = '0;
            phase_next      = PH_PULSE;
          end
        end
      endcase
    end
  end

  // sequencer state register; any register write restarts the protocol
  always_ff @(posedge clk) begin
    if (rst || cfg_fire) begin
      phase        <= PH_PULSE;
      tick_count   <= '0;
      level_offset <= '0;
      cycle_count  <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      level_offset <= level_offset_next;
      cycle_count  <= cycle_count_next;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_restart <= restart;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      current     <= cur_next;
      stimulating <= stim_next;
      done_res    <= done_next;
    end
  end

  // checks
  a_stim_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(stimulating && done_res))
    else $error("step driven after completion");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !stimulating) |-> (current == '0))
    else $error("nonzero current outside a step");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_fire |=> (phase == PH_PULSE && cycle_count == '0 && tick_count == '0))
    else $error("register write did not restart the sequencer");

  a_wrap_clears_offset: assert property (@(posedge clk) disable iff (rst)
    (advance && !cfg_fire && cycle_count_next != cc) |=> (level_offset == '0))
    else $error("offset kept across a cycle boundary");

endmodule

`default_nettype wire
